// ===== rtl/msl_pkg.sv =====
// Shared types and constants for the MAC source learning table.
// Used by msl_ctrl, msl_dpath and the top level; no dependencies.
`default_nettype none

package msl_pkg;

  // Field widths of the stream payloads
  localparam int unsigned FC_W    = 8;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned COUNT_W = 7;

  // Frame type codes taken from frame control bits 3:2
  localparam logic [CLASS_W-1:0] CLASS_MGMT = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_CTRL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DATA = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_RSVD = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // latch a new frame, reset search and flags
    logic search;  // issue table reads while entries remain
    logic append;  // store the address, or flag the table as full
    logic load;    // move the result into the output register
  } msl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic learnable;  // latched frame is management or data
    logic empty;      // no entries stored
    logic hit;        // registered entry matches the address
    logic miss;       // last entry compared without a match
    logic out_free;   // output register can take a result
  } msl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mac_source_learning_table_unit.sv =====
// MAC source learning table: learns 802.11 source addresses per frame.
// Top level; instantiates msl_ctrl and msl_dpath, uses msl_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transaction per frame, carrying the first
//   frame control byte and the 48-bit source address. Output stream
//   (m_axis_*): one transaction per frame with the frame class in tuser and
//   the learned flag, table-full flag and device count in tdata.
//   Management and data frames are looked up by a linear search that reads
//   one stored entry per cycle from a single-port table (registered read).
//   One frame is processed at a time; the next frame is accepted in the
//   cycle the result turns valid.
//   Reset clears the device count; the table contents need no clearing, as
//   only entries below the count are read. Reset leaves no result pending.
//   If the receiver stalls, the result waits in the output register; the
//   next frame is accepted and processed, then holds until the slot frees.
`default_nettype none

module mac_source_learning_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // [7:0] frame_control, [55:8] source_address
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [55:0] s_axis_tdata,
  // [0] newly_learned, [1] table_full, [8:2] device_count, [15:9] zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,
  // [1:0] frame_class
  output logic [1:0]  m_axis_tuser
);
  import msl_pkg::*;

  msl_cmd_t           cmd;
  msl_sts_t           sts;
  logic               out_learned, out_full;
  logic [COUNT_W-1:0] out_count;

  // Sequencer
  msl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, search and result register
  msl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_class_i    (s_axis_tdata[3:2]),
    .in_addr_i     (s_axis_tdata[55:8]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_class_o   (m_axis_tuser),
    .out_learned_o (out_learned),
    .out_full_o    (out_full),
    .out_count_o   (out_count)
  );

  // Result packing
  assign m_axis_tdata = {7'd0, out_count, out_full, out_learned};

endmodule

`default_nettype wire

// ===== rtl/msl_ctrl.sv =====
// Controller state machine for the MAC source learning table.
// Depends on msl_pkg; drives msl_dpath through msl_cmd_t / msl_sts_t.
`default_nettype none

module msl_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  msl_pkg::msl_sts_t  sts_i,
  output msl_pkg::msl_cmd_t  cmd_o
);
  import msl_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts_i.learnable) begin
          state_d = ST_DONE;
        end else if (sts_i.empty) begin
          state_d = ST_APPEND;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_DONE;
        end else if (sts_i.miss) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/msl_dpath.sv =====
// Datapath of the MAC source learning table: address store, search
// pointer, device count and output register. Depends on msl_pkg.
`default_nettype none

module msl_dpath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  msl_pkg::msl_cmd_t                 cmd_i,
  output msl_pkg::msl_sts_t                 sts_o,
  input  wire [msl_pkg::CLASS_W-1:0]        in_class_i,
  input  wire [msl_pkg::ADDR_W-1:0]         in_addr_i,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output logic [msl_pkg::CLASS_W-1:0]       out_class_o,
  output logic                              out_learned_o,
  output logic                              out_full_o,
  output logic [msl_pkg::COUNT_W-1:0]       out_count_o
);
  import msl_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [ADDR_W-1:0]  mem_q [TABLE_DEPTH];
  logic [ADDR_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CLASS_W-1:0] class_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic               rd_v_q, rd_v_d;
  logic               learned_q, full_q;
  logic               out_v_q, out_v_d;
  logic               rd_en, wr_en, is_full;

  assign is_full = (count_q == CntW'(TABLE_DEPTH));
  assign rd_en   = cmd_i.search && (rd_idx_q < count_q);
  assign wr_en   = cmd_i.append && !is_full;

  // Status toward the controller
  always_comb begin
    sts_o.learnable = (class_q == CLASS_MGMT) || (class_q == CLASS_DATA);
    sts_o.empty     = (count_q == '0);
    sts_o.hit       = rd_v_q && (rd_data_q == addr_q);
    sts_o.miss      = rd_v_q && (rd_data_q != addr_q) && (rd_idx_q == count_q);
    sts_o.out_free  = !out_v_q || out_ready_i;
  end

  // Address store: one write port at the fill point, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= addr_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  // Latched frame
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      class_q <= in_class_i;
      addr_q  <= in_addr_i;
    end
  end

  // Search pointer and read-data valid
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.start) begin
      rd_idx_d = '0;
    end else if (rd_en) begin
      rd_idx_d = rd_idx_q + CntW'(1);
    end
    rd_v_d = rd_en;
    count_d = wr_en ? (count_q + CntW'(1)) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rd_v_q   <= 1'b0;
      count_q  <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
      rd_v_q   <= rd_v_d;
      count_q  <= count_d;
    end
  end

  // Per-frame result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learned_q <= 1'b0;
      full_q    <= 1'b0;
    end else if (cmd_i.start) begin
      learned_q <= 1'b0;
      full_q    <= 1'b0;
    end else if (cmd_i.append) begin
      learned_q <= !is_full;
      full_q    <= is_full;
    end
  end

  // Output register
  always_comb begin
    out_v_d = out_v_q;
    if (cmd_i.load) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_class_o   <= class_q;
      out_learned_o <= learned_q;
      out_full_o    <= full_q;
      out_count_o   <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_v_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("device count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("count did not advance on insert");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(learned_q && full_q))
    else $error("learned and full both set");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_v_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_no_search_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= count_q)
    else $error("search pointer beyond stored entries");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for mac_source_learning_table_unit.
// Drives frames over the input stream and checks every result against an
// in-bench predictor of the learned-address table; depends on msl_pkg.
`default_nettype none

module tb;
  import msl_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int DEPTH          = 64;
  localparam int RANDOM_FRAMES  = 1135;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct packed {
    logic [FC_W-1:0]   frame_control;
    logic [ADDR_W-1:0] source_address;
  } frame_t;

  typedef struct packed {
    logic [CLASS_W-1:0] frame_class;
    logic               newly_learned;
    logic               table_full;
    logic [COUNT_W-1:0] device_count;
  } lookup_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  frame_t            frames_to_send[$];
  lookup_result_t    expected_results[$];
  logic [ADDR_W-1:0] learned_addrs[$];   // predicted table contents, in insert order
  logic [ADDR_W-1:0] sent_pool[$];       // addresses already sent as mgmt/data frames

  bit in_fire;
  bit out_fire;
  int mismatch_cnt = 0;
  int idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mac_source_learning_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    // [7:0] frame_control, [55:8] source_address
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    // [0] newly_learned, [1] table_full, [8:2] device_count, [15:9] zero
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    // [1:0] frame_class
    .m_axis_tuser (m_axis_tuser)
  );

  // Predicted result of one frame; updates the predicted table
  function automatic lookup_result_t predict_lookup(input logic [FC_W-1:0] fc,
                                                    input logic [ADDR_W-1:0] addr);
    lookup_result_t res;
    bit found;
    res.frame_class   = fc[3:2];
    res.newly_learned = 1'b0;
    res.table_full    = 1'b0;
    found = 1'b0;
    if (fc[3:2] == CLASS_MGMT || fc[3:2] == CLASS_DATA) begin
      foreach (learned_addrs[k]) begin
        if (learned_addrs[k] == addr) found = 1'b1;
      end
      if (!found) begin
        if (learned_addrs.size() < DEPTH) begin
          learned_addrs.push_back(addr);
          res.newly_learned = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
    end
    res.device_count = COUNT_W'(learned_addrs.size());
    return res;
  endfunction

  task automatic report_field(input string field, input logic [COUNT_W-1:0] exp_v,
                              input logic [COUNT_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    mismatch_cnt++;
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_result();
    lookup_result_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual class %0d tdata %h",
               $time, m_axis_tuser, m_axis_tdata);
      mismatch_cnt++;
    end else begin
      exp_r = expected_results.pop_front();
      if (m_axis_tuser !== exp_r.frame_class)
        report_field("frame_class", COUNT_W'(exp_r.frame_class), COUNT_W'(m_axis_tuser));
      if (m_axis_tdata[0] !== exp_r.newly_learned)
        report_field("newly_learned", COUNT_W'(exp_r.newly_learned),
                     COUNT_W'(m_axis_tdata[0]));
      if (m_axis_tdata[1] !== exp_r.table_full)
        report_field("table_full", COUNT_W'(exp_r.table_full), COUNT_W'(m_axis_tdata[1]));
      if (m_axis_tdata[8:2] !== exp_r.device_count)
        report_field("device_count", exp_r.device_count, m_axis_tdata[8:2]);
      if (m_axis_tdata[15:9] !== 7'd0)
        report_field("tdata padding", 7'd0, m_axis_tdata[15:9]);
    end
  endtask

  function automatic void push_frame(input logic [FC_W-1:0] fc,
                                     input logic [ADDR_W-1:0] addr);
    frame_t f;
    f.frame_control  = fc;
    f.source_address = addr;
    frames_to_send.push_back(f);
    if (fc[3:2] == CLASS_MGMT || fc[3:2] == CLASS_DATA) sent_pool.push_back(addr);
  endfunction

  // Monitor: predict on input transactions, check output transactions, watchdog
  always @(posedge clk_i) begin
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (in_fire)
      expected_results.push_back(predict_lookup(s_axis_tdata[7:0], s_axis_tdata[55:8]));
    if (out_fire) check_result();
    idle_cycles = (in_fire || out_fire || !rst_ni) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver: bursts of frames with random gaps in between
  int     burst_left = 0;
  int     gap_left = 0;
  frame_t cur_frame;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left != 0 || frames_to_send.size() == 0) begin
        if (gap_left != 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_frame = frames_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_frame.source_address, cur_frame.frame_control};
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1, 2:    gap_left = $urandom_range(1, 12);
            default: gap_left = $urandom_range(13, 90);
          endcase
        end
      end
    end
  end

  // Receiver: stretches of ready, random toggling, and long stalls
  int   rdy_hold = 0;
  logic rdy_next = 1'b1;

  always @(negedge clk_i) begin
    if (rdy_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rdy_next = 1'b1;
          rdy_hold = $urandom_range(10, 80);
        end
        1, 2: begin
          rdy_next = 1'($urandom_range(0, 1));
          rdy_hold = $urandom_range(0, 3);
        end
        default: begin
          rdy_next = 1'b0;
          rdy_hold = $urandom_range(20, 120);
        end
      endcase
    end else begin
      rdy_hold--;
    end
    m_axis_tready <= rdy_next;
  end

  // Stimulus, reset and end of run
  initial begin
    logic [FC_W-1:0]   fc;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        kind;
    int                r;

    // Directed: empty table, byte-0-only and last-byte-only differences,
    // ignored frame control bits, control/reserved frames leaving the table alone
    push_frame(8'h04, 48'hFFFF_FFFF_FFFF);   // control on empty table
    push_frame(8'h0C, 48'h0000_0000_0000);   // reserved on empty table
    push_frame(8'h00, 48'h0000_0000_0000);   // first learn
    push_frame(8'h08, 48'h0000_0000_0000);   // hit on first entry
    push_frame(8'hF8, 48'hFFFF_FFFF_FFFF);   // data, upper bits set
    push_frame(8'hF3, 48'hFFFF_FFFF_FFFF);   // mgmt, other bits set, hit
    push_frame(8'h00, 48'h0100_0000_0000);   // differs only in byte 0
    push_frame(8'h08, 48'h0000_0000_0001);   // differs only in last byte
    push_frame(8'h08, 48'h0100_0000_0000);   // hit
    push_frame(8'h00, 48'hFEFF_FFFF_FFFF);   // byte 0 differs from all ones
    push_frame(8'h08, 48'h7FFF_FFFF_FFFF);
    push_frame(8'hF7, 48'h1234_5678_9ABC);   // control, not stored
    push_frame(8'hFF, 48'h1234_5678_9ABC);   // reserved, not stored
    push_frame(8'h00, 48'h1234_5678_9ABC);   // learned now
    push_frame(8'h08, 48'h1234_5678_9ABC);   // hit on last entry
    push_frame(8'h00, 48'hAAAA_AAAA_AAAA);
    push_frame(8'h08, 48'h5555_5555_5555);
    push_frame(8'h04, 48'h0000_0000_0000);   // control with stored address
    push_frame(8'h08, 48'h0000_0000_0000);   // hit on first entry again

    // Random: mostly repeats of sent addresses so the table fills gradually,
    // then keeps probing hits and full-table misses
    repeat (RANDOM_FRAMES) begin
      fc = FC_W'($urandom);
      r  = $urandom_range(0, 7);
      kind = (r < 3) ? CLASS_MGMT : (r < 6) ? CLASS_DATA : (r == 6) ? CLASS_CTRL : CLASS_RSVD;
      fc[3:2] = kind;
      if (kind == CLASS_MGMT || kind == CLASS_DATA) begin
        if ($urandom_range(0, 15) < 2) begin
          addr = ADDR_W'({$urandom, $urandom});
          // near miss: one bit away from a sent address
          if ($urandom_range(0, 1)) begin
            addr = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
            addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
          end
        end else begin
          addr = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
        end
      end else begin
        addr = $urandom_range(0, 1) ? ADDR_W'({$urandom, $urandom})
                                    : sent_pool[$urandom_range(0, sent_pool.size() - 1)];
      end
      push_frame(fc, addr);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (frames_to_send.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
